### hdl/assert_macros.svh
// Assertion macros shared by the transliterator RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

### hdl/u2a_pkg.sv
// Shared types and constants for the UTF-8 punctuation transliterator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package u2a_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] B_E2   = 8'hE2;
  localparam logic [7:0] B_80   = 8'h80;
  localparam logic [7:0] B_98   = 8'h98;
  localparam logic [7:0] B_99   = 8'h99;
  localparam logic [7:0] B_9C   = 8'h9C;
  localparam logic [7:0] B_9D   = 8'h9D;
  localparam logic [7:0] B_93   = 8'h93;
  localparam logic [7:0] B_94   = 8'h94;
  localparam logic [7:0] B_A6   = 8'hA6;
  localparam logic [7:0] M_E0   = 8'hE0;
  localparam logic [7:0] M_F0   = 8'hF0;
  localparam logic [7:0] M_F8   = 8'hF8;
  localparam logic [7:0] V_C0   = 8'hC0;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_LEAD = 2'd1;
  localparam logic [1:0] PH_SEC  = 2'd2;

  // One queued command: emit ch cnt times (cnt is 1 to 3).
  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic [1:0] cnt;
    logic       last;
  } cmd_t;

endpackage

### hdl/u2a_front.sv
// Front end: decodes UTF-8 bytes into emit commands and tracks sequence state.
// Depends on u2a_pkg.
module u2a_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_text_last,
  input  logic          q_ready,
  output logic          push,
  output u2a_pkg::cmd_t push_cmd
);
  import u2a_pkg::*;

  logic [1:0] skip_r, skip_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       sec80_r, sec80_nxt;
  logic       accept;
  logic       emit;
  logic [7:0] ch;
  logic [1:0] cnt;

  assign accept = in_valid && q_ready;

  always_comb begin
    skip_nxt  = skip_r;
    phase_nxt = phase_r;
    sec80_nxt = sec80_r;
    emit      = 1'b0;
    ch        = 8'h00;
    cnt       = 2'd1;
    priority if (phase_r == PH_LEAD) begin
      sec80_nxt = (in_byte == B_80);
      phase_nxt = PH_SEC;
    end else if (phase_r != PH_NONE) begin
      if (sec80_r) begin
        if (in_byte == B_98 || in_byte == B_99) begin
          emit = 1'b1;
          ch   = CH_APOS;
        end else if (in_byte == B_9C || in_byte == B_9D) begin
          emit = 1'b1;
          ch   = CH_QUOTE;
        end else if (in_byte == B_93 || in_byte == B_94) begin
          emit = 1'b1;
          ch   = CH_DASH;
        end else if (in_byte == B_A6) begin
          emit = 1'b1;
          ch   = CH_DOT;
          cnt  = 2'd3;
        end
      end
      phase_nxt = PH_NONE;
      sec80_nxt = 1'b0;
    end else if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (!in_byte[7]) begin
      emit = 1'b1;
      ch   = in_byte;
    end else if (in_byte == B_E2) begin
      phase_nxt = PH_LEAD;
    end else if ((in_byte & M_E0) == V_C0) begin
      skip_nxt = 2'd1;
    end else if ((in_byte & M_F0) == M_E0) begin
      skip_nxt = 2'd2;
    end else if ((in_byte & M_F8) == M_F0) begin
      skip_nxt = 2'd3;
    end
    if (in_text_last) begin
      skip_nxt  = 2'd0;
      phase_nxt = PH_NONE;
      sec80_nxt = 1'b0;
    end
  end

  assign push          = accept && (emit || in_text_last);
  assign push_cmd.ch   = ch;
  assign push_cmd.vld  = emit;
  assign push_cmd.cnt  = cnt;
  assign push_cmd.last = in_text_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= 2'd0;
      phase_r <= PH_NONE;
      sec80_r <= 1'b0;
    end else if (accept) begin
      skip_r  <= skip_nxt;
      phase_r <= phase_nxt;
      sec80_r <= sec80_nxt;
    end
  end

endmodule

### hdl/u2a_queue.sv
// Small register queue of emit commands between the front and back ends.
// Depends on u2a_pkg and assert_macros.svh.
`include "assert_macros.svh"
module u2a_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u2a_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output u2a_pkg::cmd_t pop_cmd
);
  import u2a_pkg::*;

  cmd_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full  = (count_r != QDEPTH[QAW:0]);
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `ASSERT_NEVER(a_no_push_full, clk, rst_n, push && !not_full, "push into a full queue")
  `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && !not_empty, "pop from an empty queue")
  `ASSERT_CLK(a_ptr_gap, clk, rst_n, wr_ptr_r == (rd_ptr_r + count_r[QAW-1:0]), "pointer mismatch")

endmodule

### hdl/u2a_back.sv
// Back end: expands queued commands into one to three output requests.
// Depends on u2a_pkg and assert_macros.svh.
`include "assert_macros.svh"
module u2a_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  u2a_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_run_last,
  output logic          out_text_end
);
  import u2a_pkg::*;

  logic       busy_r;
  logic [1:0] rem_r;
  cmd_t       cur_r;
  logic       take;
  logic       final_one;

  assign final_one = (rem_r == 2'd1);
  assign take      = out_valid && out_ready;
  assign q_pop     = q_valid && (!busy_r || (take && final_one));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      rem_r  <= q_cmd.cnt;
    end else if (take) begin
      busy_r <= !final_one;
      rem_r  <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
  end

  assign out_valid      = busy_r;
  assign out_byte       = cur_r.ch;
  assign out_byte_valid = cur_r.vld;
  assign out_run_last   = final_one;
  assign out_text_end   = cur_r.last && final_one;

  `ASSERT_CLK(a_busy_rem, clk, rst_n, !busy_r || rem_r != 2'd0, "busy with no results left")
  `ASSERT_CLK(a_hold, clk, rst_n, busy_r && !out_ready |=> busy_r && $stable(rem_r),
              "stalled request changed")

endmodule

### hdl/utf8_punctuation_to_ascii_top.sv
// UTF-8 punctuation to ASCII transliterator, top level; uses u2a_pkg and the front, queue, back.
// Path: each byte's command is registered in the queue, then popped into the back end's
// request registers, which raise its first result request once the back end is free.
// Throughput: one byte per cycle while the queue is not full; an ellipsis makes three requests,
// and the four-entry command queue absorbs that while the input keeps flowing.
// Reset: rst_n (synchronous, active low) empties the queue and clears all sequence state.
module utf8_punctuation_to_ascii_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_text_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_text_end
);
  import u2a_pkg::*;

  // Front to queue: one command per byte that emits text or ends a string.
  logic push;
  cmd_t push_cmd;
  logic q_not_full;

  // Queue to back end.
  logic q_pop;
  logic q_not_empty;
  cmd_t q_cmd;

  // The front only stalls when the queue is full; a byte that produces no
  // command still needs a free slot, which keeps the handshake simple.
  // After reset the queue is empty, so in_ready is high from the first cycle.
  assign in_ready = q_not_full;

  u2a_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_text_last (in_text_last),
    .q_ready      (q_not_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  u2a_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_cmd)
  );

  // The back end holds the current request in registers, so a stalled
  // output never blocks the front while the queue has room.
  u2a_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_text_end   (out_text_end)
  );

endmodule
